// ----- design/kuct_pkg.sv -----
package kuct_pkg;

    localparam int unsigned DEF_MODULES          = 16;
    localparam int unsigned DEF_SLOTS_PER_MODULE = 16;
    localparam int unsigned DEF_KEY_BYTES        = 8;

    localparam int unsigned KEY_W  = 64;
    localparam int unsigned CNT_W  = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MOD_FULL  = 3'd1,
        ST_SLOT_FULL = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_UNDERFLOW = 3'd4
    } t_status;

    // request token that walks the chain of module cells
    typedef struct packed {
        logic             vld;
        logic             done;
        logic             op;
        logic [KEY_W-1:0] mkey;
        logic [KEY_W-1:0] nkey;
        logic [CNT_W-1:0] size;
        t_status          status;
        logic [CNT_W-1:0] mtot;
        logic [CNT_W-1:0] ntot;
    } t_token;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ----- design/kuct_cell.sv -----
module kuct_cell import kuct_pkg::*; #(
    parameter int unsigned SLOTS_PER_MODULE = DEF_SLOTS_PER_MODULE
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    localparam int unsigned SW = (SLOTS_PER_MODULE > 1) ? $clog2(SLOTS_PER_MODULE) : 1;

    logic                    r_valid;
    logic [KEY_W-1:0]        r_tag;
    logic [CNT_W-1:0]        r_count;
    logic [SLOTS_PER_MODULE-1:0] r_svalid;
    logic [KEY_W-1:0]        r_stag   [SLOTS_PER_MODULE];
    logic [CNT_W-1:0]        r_scount [SLOTS_PER_MODULE];
    t_token                  r_tok;

    t_token           n_tok;
    logic             act, hit;
    logic             m_any, f_any;
    logic [SW-1:0]    m_idx, f_idx;
    logic [CNT_W-1:0] sel_cnt;
    logic             claim;
    logic             we_mcnt;
    logic [CNT_W-1:0] n_count;
    logic             we_slot, slot_new;
    logic [SW-1:0]    slot_idx;
    logic [CNT_W-1:0] n_scount;

    // lowest matching slot and lowest free slot
    always_comb begin
        m_any = 1'b0;
        f_any = 1'b0;
        m_idx = '0;
        f_idx = '0;
        for (int i = SLOTS_PER_MODULE - 1; i >= 0; i--) begin
            if (r_svalid[i] && r_stag[i] == i_tok.nkey) begin
                m_any = 1'b1;
                m_idx = SW'(i);
            end
            if (!r_svalid[i]) begin
                f_any = 1'b1;
                f_idx = SW'(i);
            end
        end
    end

    assign sel_cnt = r_scount[m_idx];
    assign act     = i_tok.vld && !i_tok.done;
    assign hit     = r_valid && (r_tag == i_tok.mkey);

    always_comb begin
        n_tok    = i_tok;
        claim    = 1'b0;
        we_mcnt  = 1'b0;
        n_count  = r_count;
        we_slot  = 1'b0;
        slot_new = 1'b0;
        slot_idx = m_idx;
        n_scount = sel_cnt;
        if (act && hit) begin
            n_tok.done = 1'b1;
            n_tok.ntot = '0;
            n_tok.mtot = r_count;
            if (i_tok.op == OP_ALLOC) begin
                if (m_any) begin
                    we_mcnt     = 1'b1;
                    we_slot     = 1'b1;
                    n_count     = sat_add(r_count, i_tok.size);
                    n_scount    = sat_add(sel_cnt, i_tok.size);
                    n_tok.status = ST_OK;
                    n_tok.mtot  = n_count;
                    n_tok.ntot  = n_scount;
                end else if (f_any) begin
                    we_mcnt     = 1'b1;
                    we_slot     = 1'b1;
                    slot_new    = 1'b1;
                    slot_idx    = f_idx;
                    n_count     = sat_add(r_count, i_tok.size);
                    n_scount    = i_tok.size;
                    n_tok.status = ST_OK;
                    n_tok.mtot  = n_count;
                    n_tok.ntot  = i_tok.size;
                end else begin
                    n_tok.status = ST_SLOT_FULL;
                end
            end else begin
                if (!m_any) begin
                    n_tok.status = ST_NOT_FOUND;
                end else if (sel_cnt >= i_tok.size && r_count >= i_tok.size) begin
                    we_mcnt     = 1'b1;
                    we_slot     = 1'b1;
                    n_count     = r_count - i_tok.size;
                    n_scount    = sel_cnt - i_tok.size;
                    n_tok.status = ST_OK;
                    n_tok.mtot  = n_count;
                    n_tok.ntot  = n_scount;
                end else begin
                    n_tok.status = ST_UNDERFLOW;
                    n_tok.ntot  = sel_cnt;
                end
            end
        end else if (act && !r_valid) begin
            // entries fill in order, so the first free cell means no match anywhere
            n_tok.done = 1'b1;
            if (i_tok.op == OP_ALLOC) begin
                claim        = 1'b1;
                n_tok.status = ST_OK;
                n_tok.mtot   = i_tok.size;
                n_tok.ntot   = i_tok.size;
            end else begin
                n_tok.status = ST_NOT_FOUND;
                n_tok.mtot   = '0;
                n_tok.ntot   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_svalid <= '0;
            r_tok    <= '0;
        end else begin
            r_tok <= n_tok;
            if (claim) begin
                r_valid     <= 1'b1;
                r_tag       <= i_tok.mkey;
                r_count     <= i_tok.size;
                r_svalid    <= SLOTS_PER_MODULE'(1);
                r_stag[0]   <= i_tok.nkey;
                r_scount[0] <= i_tok.size;
            end else begin
                if (we_mcnt) begin
                    r_count <= n_count;
                end
                if (we_slot) begin
                    r_scount[slot_idx] <= n_scount;
                    if (slot_new) begin
                        r_svalid[slot_idx] <= 1'b1;
                        r_stag[slot_idx]   <= i_tok.nkey;
                    end
                end
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- design/keyed_usage_counter_table.sv -----
// the start transfer is registered, then the request token walks the chain of
// module cells one cell per cycle to the result transfer; one request at a time,
// busy holds until its result is out
// reset: synchronous active low, clears all module and slot valid bits at once
// the result strobe lasts one cycle and the receiver cannot stall it
module keyed_usage_counter_table import kuct_pkg::*; #(
    parameter int unsigned MODULES          = DEF_MODULES,
    parameter int unsigned SLOTS_PER_MODULE = DEF_SLOTS_PER_MODULE,
    parameter int unsigned KEY_BYTES        = DEF_KEY_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_operation,
    input  logic [KEY_W-1:0]  i_module_key,
    input  logic [KEY_W-1:0]  i_name_key,
    input  logic [CNT_W-1:0]  i_size,
    output logic              o_strobe,
    output logic [2:0]        o_status,
    output logic [CNT_W-1:0]  o_module_total,
    output logic [CNT_W-1:0]  o_name_total
);

    logic   r_busy;
    t_token r_tok0;
    t_token n_tok0;
    t_token tok [MODULES+1];
    t_token last;
    logic   accept;

    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= KEY_BYTES || k[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        n_tok0        = '0;
        n_tok0.vld    = accept;
        n_tok0.op     = i_operation;
        n_tok0.mkey   = norm_key(i_module_key);
        n_tok0.nkey   = norm_key(i_name_key);
        n_tok0.size   = i_size;
        n_tok0.status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tok0 <= '0;
        end else begin
            r_tok0 <= n_tok0;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < MODULES; g++) begin : g_cell
        kuct_cell #(
            .SLOTS_PER_MODULE(SLOTS_PER_MODULE)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (tok[g]),
            .o_tok  (tok[g+1])
        );
    end

    assign last = tok[MODULES];

    // result from the last cell; a token that passed every cell unclaimed: table full or nothing to release
    always_comb begin
        o_strobe = last.vld;
        if (last.done) begin
            o_status       = last.status;
            o_module_total = last.mtot;
            o_name_total   = last.ntot;
        end else begin
            o_status       = (last.op == OP_FREE) ? ST_NOT_FOUND : ST_MOD_FULL;
            o_module_total = '0;
            o_name_total   = '0;
        end
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_busy) else $error("result without a request in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy) else $error("busy not raised after transfer");

    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !r_busy) else $error("busy held after result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status <= ST_UNDERFLOW)) else $error("bad status code");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok0.vld |-> !last.vld) else $error("two tokens in the chain");

endmodule
